@@ src/lavm_pkg.sv @@
// Shared types, constants and helper functions for the look-at view matrix core.
// Used by every design module of the block; depends on nothing else.
package lavm_pkg;

    localparam int COORD_W   = 32;
    localparam int FWD_W     = 33;
    localparam int NORM_W    = 50;
    localparam int UNIT_W    = 18;
    localparam int FRAC_W    = 16;
    localparam int M_W       = 30;
    localparam int SUMSQ_W   = 62;
    localparam int ROOT_W    = 31;
    localparam int QUO_W     = 17;
    localparam int DIVREM_W  = 48;
    localparam int TOP_POS   = 29;
    localparam int POS_W     = 6;
    // normalizer depth: abs, lead, shift, square, sum, root steps, div load, div steps, out
    localparam int NORM_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;
    localparam int Q_DEPTH   = 4;

    localparam logic signed [63:0] UNIT_ONE = 64'sd65536;
    localparam logic signed [63:0] T_MAX    = 64'sd2147483647;
    localparam logic signed [63:0] T_MIN    = -64'sd2147483648;

    typedef logic [2:0][COORD_W-1:0] vec32_t;
    typedef logic [2:0][UNIT_W-1:0]  unit3_t;

    // one queued word: eye, up hint and forward difference
    typedef struct packed {
        vec32_t                  eye;
        vec32_t                  up;
        logic [2:0][FWD_W-1:0]   fwd;
    } item_t;

    // position of the highest set bit
    function automatic logic [POS_W-1:0] lead_pos(input logic [NORM_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < NORM_W; i++) begin
            if (x[i]) p = POS_W'(i);
        end
        return p;
    endfunction

    // divide by 2^16, rounding half away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + 64'd32768) >> FRAC_W;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > UNIT_ONE) ? UNIT_ONE : ((x < -UNIT_ONE) ? -UNIT_ONE : x);
        return y[UNIT_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > T_MAX) ? T_MAX : ((x < T_MIN) ? T_MIN : x);
        return y[COORD_W-1:0];
    endfunction

endpackage

@@ src/lavm_delay.sv @@
// Fixed-length delay line: a reset-cleared valid lane plus a data lane.
// Depends on lavm_pkg.
module lavm_delay
    import lavm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = NORM_LAT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vin,
    input  logic [WIDTH-1:0] din,
    output logic             vout,
    output logic [WIDTH-1:0] dout
);

    logic [DEPTH-1:0]       v_reg;
    logic [WIDTH-1:0]       d_reg [DEPTH];

    // advance the valid lane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DEPTH-2:0], vin};
        end
    end

    // advance the data lane
    always_ff @(posedge clk)
    begin
        d_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            d_reg[i] <= d_reg[i-1];
        end
    end

    assign vout = v_reg[DEPTH-1];
    assign dout = d_reg[DEPTH-1];

endmodule

@@ src/lavm_norm.sv @@
// Pipelined vector normalizer: scale to a common exponent, square root by
// one bit per stage, then three restoring dividers. Depends on lavm_pkg.
module lavm_norm
    import lavm_pkg::*;
(
    input  logic                    clk,
    input  logic [2:0][NORM_W-1:0]  vec,
    output unit3_t                  unit
);

    logic [2:0][NORM_W-1:0] mag_a_reg;
    logic [2:0]             sgn_a_reg;
    logic [2:0][NORM_W-1:0] mag_b_reg;
    logic [2:0]             sgn_b_reg;
    logic                   zero_b_reg;
    logic [POS_W-1:0]       pos_b_reg;
    logic [2:0][M_W-1:0]    m_c_reg;
    logic [2:0]             sgn_c_reg;
    logic                   zero_c_reg;
    logic [2:0][M_W-1:0]    m_d_reg;
    logic [2:0][2*M_W-1:0]  sq_d_reg;
    logic [2:0]             sgn_d_reg;
    logic                   zero_d_reg;

    logic [SUMSQ_W-1:0]     rt_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]      rt_root_reg [ROOT_W+1];
    logic [2:0][M_W-1:0]    rt_m_reg    [ROOT_W+1];
    logic [2:0]             rt_sgn_reg  [ROOT_W+1];
    logic                   rt_zero_reg [ROOT_W+1];

    logic [2:0][DIVREM_W-1:0] dv_rem_reg  [QUO_W+1];
    logic [2:0][QUO_W-1:0]    dv_q_reg    [QUO_W+1];
    logic [ROOT_W-1:0]        dv_len_reg  [QUO_W+1];
    logic [2:0]               dv_sgn_reg  [QUO_W+1];
    logic                     dv_zero_reg [QUO_W+1];

    unit3_t                 unit_reg;

    // take magnitudes and signs
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a_reg[i] <= vec[i][NORM_W-1] ? NORM_W'(-vec[i]) : vec[i];
            sgn_a_reg[i] <= vec[i][NORM_W-1];
        end
    end

    // find the leading one of the largest magnitude
    always_ff @(posedge clk)
    begin
        mag_b_reg  <= mag_a_reg;
        sgn_b_reg  <= sgn_a_reg;
        pos_b_reg  <= lead_pos(mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2]);
        zero_b_reg <= ((mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2]) == '0);
    end

    // shift all components by the common amount
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos_b_reg >= POS_W'(TOP_POS))
                m_c_reg[i] <= M_W'(mag_b_reg[i] >> (pos_b_reg - POS_W'(TOP_POS)));
            else
                m_c_reg[i] <= M_W'(mag_b_reg[i] << (POS_W'(TOP_POS) - pos_b_reg));
        end
        sgn_c_reg  <= sgn_b_reg;
        zero_c_reg <= zero_b_reg;
    end

    // square each component
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_d_reg[i] <= (2*M_W)'(m_c_reg[i]) * (2*M_W)'(m_c_reg[i]);
        end
        m_d_reg    <= m_c_reg;
        sgn_d_reg  <= sgn_c_reg;
        zero_d_reg <= zero_c_reg;
    end

    // sum squares, then resolve one root bit per stage
    always_ff @(posedge clk)
    begin
        logic [63:0] trial;
        rt_rem_reg[0]  <= SUMSQ_W'(sq_d_reg[0]) + SUMSQ_W'(sq_d_reg[1])
                          + SUMSQ_W'(sq_d_reg[2]);
        rt_root_reg[0] <= '0;
        rt_m_reg[0]    <= m_d_reg;
        rt_sgn_reg[0]  <= sgn_d_reg;
        rt_zero_reg[0] <= zero_d_reg;
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial = (64'(rt_root_reg[k]) << (ROOT_W - k))
                    | (64'd1 << (2 * (ROOT_W - 1 - k)));
            if (64'(rt_rem_reg[k]) >= trial)
            begin
                rt_rem_reg[k+1]  <= SUMSQ_W'(64'(rt_rem_reg[k]) - trial);
                rt_root_reg[k+1] <= rt_root_reg[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rt_rem_reg[k+1]  <= rt_rem_reg[k];
                rt_root_reg[k+1] <= rt_root_reg[k];
            end
            rt_m_reg[k+1]    <= rt_m_reg[k];
            rt_sgn_reg[k+1]  <= rt_sgn_reg[k];
            rt_zero_reg[k+1] <= rt_zero_reg[k];
        end
    end

    // divide each scaled component by the length, one quotient bit per stage
    always_ff @(posedge clk)
    begin
        logic [DIVREM_W-1:0] dsr;
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= DIVREM_W'({rt_m_reg[ROOT_W][i], {FRAC_W{1'b0}}});
        end
        dv_q_reg[0]    <= '0;
        dv_len_reg[0]  <= rt_root_reg[ROOT_W];
        dv_sgn_reg[0]  <= rt_sgn_reg[ROOT_W];
        dv_zero_reg[0] <= rt_zero_reg[ROOT_W];
        for (int k = 0; k < QUO_W; k++)
        begin
            dsr = DIVREM_W'(dv_len_reg[k]) << (QUO_W - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_rem_reg[k][i] >= dsr)
                begin
                    dv_rem_reg[k+1][i] <= dv_rem_reg[k][i] - dsr;
                    dv_q_reg[k+1][i]   <= dv_q_reg[k][i] | (QUO_W'(1) << (QUO_W - 1 - k));
                end
                else
                begin
                    dv_rem_reg[k+1][i] <= dv_rem_reg[k][i];
                    dv_q_reg[k+1][i]   <= dv_q_reg[k][i];
                end
            end
            dv_len_reg[k+1]  <= dv_len_reg[k];
            dv_sgn_reg[k+1]  <= dv_sgn_reg[k];
            dv_zero_reg[k+1] <= dv_zero_reg[k];
        end
    end

    // apply signs; a zero vector stays zero
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[QUO_W])
                unit_reg[i] <= '0;
            else if (dv_sgn_reg[QUO_W][i])
                unit_reg[i] <= UNIT_W'(-UNIT_W'(dv_q_reg[QUO_W][i]));
            else
                unit_reg[i] <= UNIT_W'(dv_q_reg[QUO_W][i]);
        end
    end

    assign unit = unit_reg;

endmodule

@@ src/lavm_front.sv @@
// Front end: takes a command word, forms the forward difference, hands it on.
// Depends on lavm_pkg.
module lavm_front
    import lavm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   busy,
    input  vec32_t eye,
    input  vec32_t target,
    input  vec32_t up,
    output logic   push,
    output item_t  item
);

    logic  push_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
        end
        else
        begin
            push_reg <= start && !busy;
        end
    end

    // capture the word and the exact 33-bit forward vector
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg.eye <= eye;
            item_reg.up  <= up;
            for (int i = 0; i < 3; i++)
            begin
                item_reg.fwd[i] <= FWD_W'($signed(target[i])) - FWD_W'($signed(eye[i]));
            end
        end
    end

    assign push = push_reg;
    assign item = item_reg;

endmodule

@@ src/lavm_queue.sv @@
// Small word queue between front and back end.
// Depends on lavm_pkg.
module lavm_queue
    import lavm_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  pop,
    output item_t pop_item,
    output logic  nearly_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // the back end never stalls: drain one word whenever one is held
    assign pop         = (count_reg != '0);
    assign pop_item    = mem[rd_ptr_reg];
    assign nearly_full = (count_reg >= CNT_W'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

@@ src/lavm_back.sv @@
// Back end: normalize forward, cross with up, normalize side, form true up
// and the three translation terms. Depends on lavm_pkg, lavm_norm, lavm_delay.
module lavm_back
    import lavm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  item_t                 in_item,
    output logic                  done,
    output unit3_t                side,
    output unit3_t                vert,
    output unit3_t                back,
    output logic [COORD_W-1:0]    side_t,
    output logic [COORD_W-1:0]    vert_t,
    output logic [COORD_W-1:0]    back_t
);

    logic                   r_v_reg;
    item_t                  r_item_reg;
    logic [2:0][NORM_W-1:0] fw_ext;
    unit3_t                 fn;
    logic                   d1_v;
    logic [2*3*COORD_W-1:0] d1_data;
    vec32_t                 d1_eye;
    vec32_t                 d1_up;

    logic                   x1_v_reg;
    logic [5:0][NORM_W-1:0] x1_p_reg;
    vec32_t                 x1_eye_reg;
    unit3_t                 x1_fn_reg;
    logic                   x2_v_reg;
    logic [2:0][NORM_W-1:0] x2_sc_reg;
    vec32_t                 x2_eye_reg;
    unit3_t                 x2_fn_reg;

    unit3_t                 sd;
    logic                   d2_v;
    logic [3*COORD_W+3*UNIT_W-1:0] d2_data;
    vec32_t                 d2_eye;
    unit3_t                 d2_fn;

    logic                   v1_v_reg;
    logic [5:0][35:0]       v1_p_reg;
    unit3_t                 v1_sd_reg;
    unit3_t                 v1_fn_reg;
    vec32_t                 v1_eye_reg;
    logic                   v2_v_reg;
    logic [2:0][36:0]       v2_s_reg;
    unit3_t                 v2_sd_reg;
    unit3_t                 v2_fn_reg;
    vec32_t                 v2_eye_reg;
    logic                   v3_v_reg;
    unit3_t                 v3_vt_reg;
    unit3_t                 v3_sd_reg;
    unit3_t                 v3_fn_reg;
    vec32_t                 v3_eye_reg;
    logic                   v4_v_reg;
    logic [8:0][NORM_W-1:0] v4_p_reg;
    unit3_t                 v4_sd_reg;
    unit3_t                 v4_vt_reg;
    unit3_t                 v4_bk_reg;
    logic                   v5_v_reg;
    logic [2:0][51:0]       v5_d_reg;
    unit3_t                 v5_sd_reg;
    unit3_t                 v5_vt_reg;
    unit3_t                 v5_bk_reg;

    logic                   done_reg;
    unit3_t                 side_reg;
    unit3_t                 vert_reg;
    unit3_t                 back_reg;
    logic [COORD_W-1:0]     side_t_reg;
    logic [COORD_W-1:0]     vert_t_reg;
    logic [COORD_W-1:0]     back_t_reg;

    // valid bits of the fixed stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg  <= 1'b0;
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
            v1_v_reg <= 1'b0;
            v2_v_reg <= 1'b0;
            v3_v_reg <= 1'b0;
            v4_v_reg <= 1'b0;
            v5_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            r_v_reg  <= in_valid;
            x1_v_reg <= d1_v;
            x2_v_reg <= x1_v_reg;
            v1_v_reg <= d2_v;
            v2_v_reg <= v1_v_reg;
            v3_v_reg <= v2_v_reg;
            v4_v_reg <= v3_v_reg;
            v5_v_reg <= v4_v_reg;
            done_reg <= v5_v_reg;
        end
    end

    // hold the popped word
    always_ff @(posedge clk)
    begin
        r_item_reg <= in_item;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fw_ext[i] = NORM_W'($signed(r_item_reg.fwd[i]));
        end
    end

    lavm_norm u_norm_fwd (
        .clk  (clk),
        .vec  (fw_ext),
        .unit (fn)
    );

    lavm_delay #(
        .WIDTH (2 * 3 * COORD_W),
        .DEPTH (NORM_LAT)
    ) u_dly_fwd (
        .clk   (clk),
        .rst_n (rst_n),
        .vin   (r_v_reg),
        .din   ({r_item_reg.eye, r_item_reg.up}),
        .vout  (d1_v),
        .dout  (d1_data)
    );

    assign d1_eye = d1_data[2*3*COORD_W-1:3*COORD_W];
    assign d1_up  = d1_data[3*COORD_W-1:0];

    // cross products of unit forward with up hint
    always_ff @(posedge clk)
    begin
        x1_p_reg[0] <= $signed(fn[1]) * $signed(d1_up[2]);
        x1_p_reg[1] <= $signed(fn[2]) * $signed(d1_up[1]);
        x1_p_reg[2] <= $signed(fn[2]) * $signed(d1_up[0]);
        x1_p_reg[3] <= $signed(fn[0]) * $signed(d1_up[2]);
        x1_p_reg[4] <= $signed(fn[0]) * $signed(d1_up[1]);
        x1_p_reg[5] <= $signed(fn[1]) * $signed(d1_up[0]);
        x1_eye_reg  <= d1_eye;
        x1_fn_reg   <= fn;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            x2_sc_reg[i] <= NORM_W'($signed(x1_p_reg[2*i]) - $signed(x1_p_reg[2*i+1]));
        end
        x2_eye_reg <= x1_eye_reg;
        x2_fn_reg  <= x1_fn_reg;
    end

    lavm_norm u_norm_side (
        .clk  (clk),
        .vec  (x2_sc_reg),
        .unit (sd)
    );

    lavm_delay #(
        .WIDTH (3 * COORD_W + 3 * UNIT_W),
        .DEPTH (NORM_LAT)
    ) u_dly_side (
        .clk   (clk),
        .rst_n (rst_n),
        .vin   (x2_v_reg),
        .din   ({x2_eye_reg, x2_fn_reg}),
        .vout  (d2_v),
        .dout  (d2_data)
    );

    assign d2_eye = d2_data[3*COORD_W+3*UNIT_W-1:3*UNIT_W];
    assign d2_fn  = d2_data[3*UNIT_W-1:0];

    // true up: side cross forward, products then differences
    always_ff @(posedge clk)
    begin
        v1_p_reg[0] <= $signed(sd[1]) * $signed(d2_fn[2]);
        v1_p_reg[1] <= $signed(sd[2]) * $signed(d2_fn[1]);
        v1_p_reg[2] <= $signed(sd[2]) * $signed(d2_fn[0]);
        v1_p_reg[3] <= $signed(sd[0]) * $signed(d2_fn[2]);
        v1_p_reg[4] <= $signed(sd[0]) * $signed(d2_fn[1]);
        v1_p_reg[5] <= $signed(sd[1]) * $signed(d2_fn[0]);
        v1_sd_reg   <= sd;
        v1_fn_reg   <= d2_fn;
        v1_eye_reg  <= d2_eye;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            v2_s_reg[i] <= 37'($signed(v1_p_reg[2*i]) - $signed(v1_p_reg[2*i+1]));
        end
        v2_sd_reg  <= v1_sd_reg;
        v2_fn_reg  <= v1_fn_reg;
        v2_eye_reg <= v1_eye_reg;
    end

    // round true up to Q1.16 and clamp to unit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            v3_vt_reg[i] <= clamp_unit(rnd16(64'($signed(v2_s_reg[i]))));
        end
        v3_sd_reg  <= v2_sd_reg;
        v3_fn_reg  <= v2_fn_reg;
        v3_eye_reg <= v2_eye_reg;
    end

    // axis times eye products
    always_ff @(posedge clk)
    begin
        logic [UNIT_W-1:0] bk;
        for (int i = 0; i < 3; i++)
        begin
            bk = UNIT_W'(-v3_fn_reg[i]);
            v4_p_reg[i]   <= $signed(v3_sd_reg[i]) * $signed(v3_eye_reg[i]);
            v4_p_reg[3+i] <= $signed(v3_vt_reg[i]) * $signed(v3_eye_reg[i]);
            v4_p_reg[6+i] <= $signed(bk) * $signed(v3_eye_reg[i]);
            v4_bk_reg[i]  <= bk;
        end
        v4_sd_reg <= v3_sd_reg;
        v4_vt_reg <= v3_vt_reg;
    end

    // dot products
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            v5_d_reg[j] <= 52'($signed(v4_p_reg[3*j]) + $signed(v4_p_reg[3*j+1])
                               + $signed(v4_p_reg[3*j+2]));
        end
        v5_sd_reg <= v4_sd_reg;
        v5_vt_reg <= v4_vt_reg;
        v5_bk_reg <= v4_bk_reg;
    end

    // negate, round and saturate the translation terms
    always_ff @(posedge clk)
    begin
        side_t_reg <= sat32(rnd16(-64'($signed(v5_d_reg[0]))));
        vert_t_reg <= sat32(rnd16(-64'($signed(v5_d_reg[1]))));
        back_t_reg <= sat32(rnd16(-64'($signed(v5_d_reg[2]))));
        side_reg   <= v5_sd_reg;
        vert_reg   <= v5_vt_reg;
        back_reg   <= v5_bk_reg;
    end

    assign done   = done_reg;
    assign side   = side_reg;
    assign vert   = vert_reg;
    assign back   = back_reg;
    assign side_t = side_t_reg;
    assign vert_t = vert_t_reg;
    assign back_t = back_t_reg;

endmodule

@@ src/look_at_view_matrix_core.sv @@
// Look-at view matrix core: top level wiring front end, word queue and back end.
// Depends on lavm_pkg, lavm_front, lavm_queue, lavm_back.
//
// Usage:
//   Present eye, target and up hint (signed Q16.16) and raise start; the word
//   is taken at a clock edge where start is high and busy is low. busy only
//   rises if the queue nears full, which the steady drain keeps from happening.
//   Each word yields one result: side, true up and back axes (Q1.16) with
//   their translation terms (Q16.16, saturated), shown for one cycle with done.
//   The receiver cannot hold results off; it must take them when done is high.
// Path: after the accepting edge a word passes the queue and the back-end input
//   register, two normalizers (31 root and 17 divide stages dominate each), the
//   cross product registers and the true up and translation registers; done
//   then rises with the results.
// Throughput: one word per cycle while busy is low; every stage is fully pipelined and the
//   two normalizers, each with three dividers, each take a new vector every cycle.
// Reset: rst_n clears the queue and all valid bits; no result is pending after.
module look_at_view_matrix_core
    import lavm_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        eye_x,
    input  logic [31:0]        eye_y,
    input  logic [31:0]        eye_z,
    input  logic [31:0]        target_x,
    input  logic [31:0]        target_y,
    input  logic [31:0]        target_z,
    input  logic [31:0]        upref_x,
    input  logic [31:0]        upref_y,
    input  logic [31:0]        upref_z,
    output logic               done,
    output logic [17:0]        side_x,
    output logic [17:0]        side_y,
    output logic [17:0]        side_z,
    output logic [31:0]        side_t,
    output logic [17:0]        vert_x,
    output logic [17:0]        vert_y,
    output logic [17:0]        vert_z,
    output logic [31:0]        vert_t,
    output logic [17:0]        back_x,
    output logic [17:0]        back_y,
    output logic [17:0]        back_z,
    output logic [31:0]        back_t
);

    logic   push;
    item_t  push_item;
    logic   pop;
    item_t  pop_item;
    unit3_t side;
    unit3_t vert;
    unit3_t back;

    lavm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .eye    ({eye_z, eye_y, eye_x}),
        .target ({target_z, target_y, target_x}),
        .up     ({upref_z, upref_y, upref_x}),
        .push   (push),
        .item   (push_item)
    );

    lavm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_item   (push_item),
        .pop         (pop),
        .pop_item    (pop_item),
        .nearly_full (busy)
    );

    lavm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .in_item  (pop_item),
        .done     (done),
        .side     (side),
        .vert     (vert),
        .back     (back),
        .side_t   (side_t),
        .vert_t   (vert_t),
        .back_t   (back_t)
    );

    assign side_x = side[0];
    assign side_y = side[1];
    assign side_z = side[2];
    assign vert_x = vert[0];
    assign vert_y = vert[1];
    assign vert_z = vert[2];
    assign back_x = back[0];
    assign back_y = back[1];
    assign back_z = back[2];

endmodule

@@ src/lavm_checker.sv @@
// Port-level checks for the look-at view matrix core, bound to the top level.
// Depends on look_at_view_matrix_core.
module lavm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [17:0] side_x,
    input logic [17:0] side_y,
    input logic [17:0] side_z,
    input logic [31:0] side_t,
    input logic [17:0] vert_x,
    input logic [17:0] vert_y,
    input logic [17:0] vert_z,
    input logic [31:0] vert_t,
    input logic [17:0] back_x,
    input logic [17:0] back_y,
    input logic [17:0] back_z,
    input logic [31:0] back_t
);

    // side axis stays within unit range
    a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(side_x) <= 18'sd65536) && ($signed(side_x) >= -18'sd65536)
              && ($signed(side_y) <= 18'sd65536) && ($signed(side_y) >= -18'sd65536)
              && ($signed(side_z) <= 18'sd65536) && ($signed(side_z) >= -18'sd65536))
        else $error("side axis out of unit range");

    // true up is clamped to unit range
    a_vert_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(vert_x) <= 18'sd65536) && ($signed(vert_x) >= -18'sd65536)
              && ($signed(vert_y) <= 18'sd65536) && ($signed(vert_y) >= -18'sd65536)
              && ($signed(vert_z) <= 18'sd65536) && ($signed(vert_z) >= -18'sd65536))
        else $error("true up out of unit range");

    // eye on target: side row and all three translation terms are zero
    a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && back_x == '0 && back_y == '0 && back_z == '0)
        |-> (side_x == '0 && side_y == '0 && side_z == '0 && back_t == '0
             && side_t == '0 && vert_t == '0))
        else $error("zero forward gave nonzero rows");

    // degenerate side: true up row and both terms are zero
    a_zero_side: assert property (@(posedge clk) disable iff (!rst_n)
        (done && side_x == '0 && side_y == '0 && side_z == '0)
        |-> (vert_x == '0 && vert_y == '0 && vert_z == '0
             && side_t == '0 && vert_t == '0))
        else $error("zero side gave nonzero true up");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (.*);
